### hdl/bracket_tree_level_order_assert.svh
// Assertion macros for the checker of the bracket tree block.
`ifndef BRACKET_TREE_LEVEL_ORDER_ASSERT_SVH
`define BRACKET_TREE_LEVEL_ORDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTO_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bracket tree check failed");

// The consequent must hold in the cycle after the antecedent.
`define BTO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bracket tree check failed");

`endif

### hdl/bto_pkg.sv
package bto_pkg;

   // Sizes of the node store and the parent stack.
   localparam int MAX_NODES   = 64;
   localparam int STACK_DEPTH = 64;
   localparam int IDX_W       = $clog2(MAX_NODES);
   localparam int STK_W       = $clog2(STACK_DEPTH);
   localparam int LINK_W      = 7;
   localparam int CNT_W       = 7;
   localparam int SYM_W       = 8;

   // Link code for "no node".
   localparam logic [LINK_W-1:0] NONE_IDX = 7'd127;

   // Characters with a special meaning.
   localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;
   localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;
   localparam logic [SYM_W-1:0] SYM_COMMA = 8'h2C;
   localparam logic [SYM_W-1:0] SYM_END   = 8'h00;

   // Side on which the next node is attached.
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_LEFT  = 2'd1;
   localparam logic [1:0] MODE_RIGHT = 2'd2;

   // Write requests from the parser into the node and link memories.
   typedef struct packed {
      logic              node_we;
      logic [IDX_W-1:0]  node_addr;
      logic [SYM_W-1:0]  node_data;
      logic              left_we;
      logic [IDX_W-1:0]  left_addr;
      logic [LINK_W-1:0] left_data;
      logic              right_we;
      logic [IDX_W-1:0]  right_addr;
      logic [LINK_W-1:0] right_data;
   } tree_wr_type;

   // Start of a breadth-first readout, issued on the terminator.
   typedef struct packed {
      logic              go;
      logic [LINK_W-1:0] root;
      logic              err;
   } start_type;

endpackage

### hdl/bto_ram.sv
module bto_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(DEPTH)-1:0]     waddr,
   input  logic [WIDTH-1:0]             wdata,
   input  logic [$clog2(DEPTH)-1:0]     raddr,
   output logic [WIDTH-1:0]             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

### hdl/bto_parser.sv
module bto_parser
   import bto_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [SYM_W-1:0] req_symbol,
   output logic             req_stall,
   input  logic             walk_busy,
   output tree_wr_type      tree_wr,
   output start_type        start
);

   logic [CNT_W-1:0]  node_count_ff, node_count_in;
   logic [LINK_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  level_ff, level_in;
   logic [1:0]        mode_ff, mode_in;
   logic [LINK_W-1:0] current_ff, current_in;
   logic              error_ff, error_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_left_ff, pend_left_in;
   logic [IDX_W-1:0]  pend_parent_ff, pend_parent_in;
   logic [IDX_W-1:0]  pend_child_ff, pend_child_in;
   logic              byp_valid_ff, byp_valid_in;
   logic [LINK_W-1:0] byp_data_ff, byp_data_in;

   logic              is_ctrl;
   logic              accept;
   logic              create;
   logic              stk_we;
   logic [CNT_W-1:0]  top_addr;
   logic [LINK_W-1:0] stk_rdata;
   logic [LINK_W-1:0] stack_top;

   // Parent stack; the read port always points at the top entry.
   bto_ram #(
      .WIDTH (LINK_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (level_ff[STK_W-1:0]),
      .wdata (current_ff),
      .raddr (top_addr[STK_W-1:0]),
      .rdata (stk_rdata)
   );

   assign top_addr  = level_in - CNT_W'(1);
   assign stack_top = byp_valid_ff ? byp_data_ff : stk_rdata;

   // A node character or the terminator waits while a child link is still pending.
   assign is_ctrl   = (req_symbol == SYM_OPEN) || (req_symbol == SYM_CLOSE) ||
                      (req_symbol == SYM_COMMA);
   assign req_stall = walk_busy || (pend_valid_ff && !is_ctrl);
   assign accept    = req_valid && !req_stall;

   // Character decode and state update.
   always_comb begin
      node_count_in  = node_count_ff;
      root_in        = root_ff;
      level_in       = level_ff;
      mode_in        = mode_ff;
      current_in     = current_ff;
      error_in       = error_ff;
      pend_valid_in  = 1'b0;
      pend_left_in   = pend_left_ff;
      pend_parent_in = pend_parent_ff;
      pend_child_in  = pend_child_ff;
      byp_valid_in   = 1'b0;
      byp_data_in    = current_ff;
      stk_we         = 1'b0;
      create         = 1'b0;
      start.go       = 1'b0;
      start.root     = root_ff;
      start.err      = error_ff;
      if (accept) begin
         unique case (req_symbol)
            SYM_END: begin
               start.go      = 1'b1;
               node_count_in = '0;
               root_in       = NONE_IDX;
               level_in      = '0;
               mode_in       = MODE_NONE;
               current_in    = NONE_IDX;
               error_in      = 1'b0;
            end
            SYM_OPEN: begin
               if (level_ff >= CNT_W'(STACK_DEPTH)) begin
                  error_in = 1'b1;
               end else begin
                  stk_we       = 1'b1;
                  level_in     = level_ff + CNT_W'(1);
                  byp_valid_in = 1'b1;
               end
               mode_in = MODE_LEFT;
            end
            SYM_CLOSE: begin
               if (level_ff == '0) begin
                  error_in = 1'b1;
               end else begin
                  level_in = level_ff - CNT_W'(1);
               end
            end
            SYM_COMMA: begin
               mode_in = MODE_RIGHT;
            end
            default: begin
               if (node_count_ff >= CNT_W'(MAX_NODES)) begin
                  error_in = 1'b1;
               end else begin
                  create        = 1'b1;
                  node_count_in = node_count_ff + CNT_W'(1);
                  current_in    = LINK_W'(node_count_ff);
                  if (root_ff == NONE_IDX) begin
                     root_in = LINK_W'(node_count_ff);
                  end else if ((mode_ff == MODE_LEFT) || (mode_ff == MODE_RIGHT)) begin
                     if (level_ff == '0) begin
                        error_in = 1'b1;
                     end else if (stack_top >= LINK_W'(MAX_NODES)) begin
                        error_in = 1'b1;
                     end else begin
                        pend_valid_in  = 1'b1;
                        pend_left_in   = (mode_ff == MODE_LEFT);
                        pend_parent_in = stack_top[IDX_W-1:0];
                        pend_child_in  = node_count_ff[IDX_W-1:0];
                     end
                  end
               end
            end
         endcase
      end
   end

   // Node creation writes the value and clears both links; the parent link
   // is written in the cycle after, when the link memories are free.
   always_comb begin
      tree_wr.node_we    = create;
      tree_wr.node_addr  = node_count_ff[IDX_W-1:0];
      tree_wr.node_data  = req_symbol;
      tree_wr.left_we    = create || (pend_valid_ff && pend_left_ff);
      tree_wr.left_addr  = create ? node_count_ff[IDX_W-1:0] : pend_parent_ff;
      tree_wr.left_data  = create ? NONE_IDX : LINK_W'(pend_child_ff);
      tree_wr.right_we   = create || (pend_valid_ff && !pend_left_ff);
      tree_wr.right_addr = create ? node_count_ff[IDX_W-1:0] : pend_parent_ff;
      tree_wr.right_data = create ? NONE_IDX : LINK_W'(pend_child_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         root_ff       <= NONE_IDX;
         level_ff      <= '0;
         mode_ff       <= MODE_NONE;
         current_ff    <= NONE_IDX;
         error_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         byp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         root_ff       <= root_in;
         level_ff      <= level_in;
         mode_ff       <= mode_in;
         current_ff    <= current_in;
         error_ff      <= error_in;
         pend_valid_ff <= pend_valid_in;
         byp_valid_ff  <= byp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_left_ff   <= pend_left_in;
      pend_parent_ff <= pend_parent_in;
      pend_child_ff  <= pend_child_in;
      byp_data_ff    <= byp_data_in;
   end

endmodule

### hdl/bto_walker.sv
module bto_walker
   import bto_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  start_type         start,
   output logic              walk_busy,
   output logic [IDX_W-1:0]  node_raddr,
   input  logic [SYM_W-1:0]  node_rdata,
   input  logic [LINK_W-1:0] left_rdata,
   input  logic [LINK_W-1:0] right_rdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SYM_W-1:0]  rsp_node_value,
   output logic              rsp_tree_empty,
   output logic              rsp_error_seen,
   output logic              rsp_is_last
);

   typedef enum logic [7:0] {
      W_IDLE   = 8'b0000_0001,
      W_START  = 8'b0000_0010,
      W_FETCH  = 8'b0000_0100,
      W_EMIT   = 8'b0000_1000,
      W_PUSH_L = 8'b0001_0000,
      W_PUSH_R = 8'b0010_0000,
      W_QREAD  = 8'b0100_0000,
      W_QWAIT  = 8'b1000_0000
   } walk_state_type;

   walk_state_type    state_ff, state_in;
   logic [LINK_W-1:0] root_ff, root_in;
   logic              err_ff, err_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  tail_ff, tail_in;
   logic [LINK_W-1:0] left_ff, left_in;
   logic [LINK_W-1:0] right_ff, right_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]  value_ff, value_in;
   logic              empty_ff, empty_in;
   logic              errout_ff, errout_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              load;
   logic              left_ok;
   logic              right_ok;
   logic [CNT_W-1:0]  tail_sum;
   logic              q_we;
   logic [IDX_W-1:0]  q_wdata;
   logic [IDX_W-1:0]  q_rdata;

   // Visit queue of node indexes.
   bto_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_NODES)
   ) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (tail_ff[IDX_W-1:0]),
      .wdata (q_wdata),
      .raddr (head_ff[IDX_W-1:0]),
      .rdata (q_rdata)
   );

   assign walk_busy  = (state_ff != W_IDLE);
   assign node_raddr = idx_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign left_ok    = (left_rdata < LINK_W'(MAX_NODES));
   assign right_ok   = (right_rdata < LINK_W'(MAX_NODES));
   assign tail_sum   = tail_ff + CNT_W'(left_ok) + CNT_W'(right_ok);

   // Breadth-first walk: fetch a node, emit it, queue its children, dequeue.
   always_comb begin
      state_in  = state_ff;
      root_in   = root_ff;
      err_in    = err_ff;
      idx_in    = idx_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      value_in  = value_ff;
      empty_in  = empty_ff;
      errout_in = errout_ff;
      last_in   = last_ff;
      load      = 1'b0;
      q_we      = 1'b0;
      q_wdata   = left_ff[IDX_W-1:0];
      unique case (state_ff)
         W_IDLE: begin
            if (start.go) begin
               root_in  = start.root;
               err_in   = start.err;
               head_in  = '0;
               tail_in  = '0;
               state_in = W_START;
            end
         end
         W_START: begin
            if (root_ff < LINK_W'(MAX_NODES)) begin
               idx_in   = root_ff[IDX_W-1:0];
               state_in = W_FETCH;
            end else if (out_free) begin
               load      = 1'b1;
               value_in  = '0;
               empty_in  = 1'b1;
               errout_in = err_ff;
               last_in   = 1'b1;
               state_in  = W_IDLE;
            end
         end
         W_FETCH: begin
            state_in = W_EMIT;
         end
         W_EMIT: begin
            if (out_free) begin
               load      = 1'b1;
               value_in  = node_rdata;
               empty_in  = 1'b0;
               errout_in = err_ff;
               last_in   = (head_ff == tail_sum);
               left_in   = left_rdata;
               right_in  = right_rdata;
               state_in  = W_PUSH_L;
            end
         end
         W_PUSH_L: begin
            if (left_ff < LINK_W'(MAX_NODES)) begin
               q_we    = 1'b1;
               tail_in = tail_ff + CNT_W'(1);
            end
            state_in = W_PUSH_R;
         end
         W_PUSH_R: begin
            q_wdata = right_ff[IDX_W-1:0];
            if (right_ff < LINK_W'(MAX_NODES)) begin
               q_we    = 1'b1;
               tail_in = tail_ff + CNT_W'(1);
            end
            state_in = (head_ff == tail_in) ? W_IDLE : W_QREAD;
         end
         W_QREAD: begin
            state_in = W_QWAIT;
         end
         W_QWAIT: begin
            idx_in   = q_rdata;
            head_in  = head_ff + CNT_W'(1);
            state_in = W_FETCH;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   // Output register: filled by the walk, emptied by a transfer.
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      root_ff   <= root_in;
      err_ff    <= err_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      value_ff  <= value_in;
      empty_ff  <= empty_in;
      errout_ff <= errout_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_value = value_ff;
   assign rsp_tree_empty = empty_ff;
   assign rsp_error_seen = errout_ff;
   assign rsp_is_last    = last_ff;

endmodule

### hdl/bracket_tree_level_order.sv
// Parsing: one character per cycle while no readout runs; a node character or the
// terminator right after an attached node waits while the parent link is written to
// the link memory. Readout: the root is emitted first (an empty tree's single result
// comes from the start state); each further node takes the queue read and its wait,
// node fetch, emit (held by any output stall) and two queue writes. Input resumes when
// the walk is idle. Reset (synchronous, active high) empties the tree, stack and error
// flag; the memories are not cleared, every entry is written before it is read.
module bracket_tree_level_order
   import bto_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [SYM_W-1:0] req_symbol,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SYM_W-1:0] rsp_node_value,
   output logic             rsp_tree_empty,
   output logic             rsp_error_seen,
   output logic             rsp_is_last
);

   tree_wr_type       tree_wr;
   start_type         start;
   logic              walk_busy;
   logic [IDX_W-1:0]  node_raddr;
   logic [SYM_W-1:0]  node_rdata;
   logic [LINK_W-1:0] left_rdata;
   logic [LINK_W-1:0] right_rdata;

   // Character parser with the parent stack.
   bto_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_symbol (req_symbol),
      .req_stall  (req_stall),
      .walk_busy  (walk_busy),
      .tree_wr    (tree_wr),
      .start      (start)
   );

   // Node values and child links, written by the parser, read by the walk.
   bto_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_NODES)
   ) u_values (
      .clock (clock),
      .we    (tree_wr.node_we),
      .waddr (tree_wr.node_addr),
      .wdata (tree_wr.node_data),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   bto_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_NODES)
   ) u_left (
      .clock (clock),
      .we    (tree_wr.left_we),
      .waddr (tree_wr.left_addr),
      .wdata (tree_wr.left_data),
      .raddr (node_raddr),
      .rdata (left_rdata)
   );

   bto_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_NODES)
   ) u_right (
      .clock (clock),
      .we    (tree_wr.right_we),
      .waddr (tree_wr.right_addr),
      .wdata (tree_wr.right_data),
      .raddr (node_raddr),
      .rdata (right_rdata)
   );

   // Breadth-first readout with the visit queue and the output register.
   bto_walker u_walker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .walk_busy      (walk_busy),
      .node_raddr     (node_raddr),
      .node_rdata     (node_rdata),
      .left_rdata     (left_rdata),
      .right_rdata    (right_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_node_value (rsp_node_value),
      .rsp_tree_empty (rsp_tree_empty),
      .rsp_error_seen (rsp_error_seen),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

### hdl/bto_checker.sv
`include "bracket_tree_level_order_assert.svh"

module bto_checker
   import bto_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [SYM_W-1:0] req_symbol,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [SYM_W-1:0] rsp_node_value,
   input logic             rsp_tree_empty,
   input logic             rsp_error_seen,
   input logic             rsp_is_last
);

   // A stalled result stays offered and unchanged.
   `BTO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_node_value) && $stable(rsp_tree_empty) && $stable(rsp_is_last))

   // An empty tree gives a single zero result.
   `BTO_ASSERT_SAME(a_empty_single, clock, reset, rsp_valid && rsp_tree_empty, rsp_is_last && (rsp_node_value == '0))

   // After the terminator is taken, input is held off for the readout.
   `BTO_ASSERT_NEXT(a_end_blocks, clock, reset, req_valid && !req_stall && (req_symbol == SYM_END), req_stall)

   // While the readout still owes results, no new character is taken.
   `BTO_ASSERT_NEXT(a_walk_blocks, clock, reset, rsp_valid && !rsp_stall && !rsp_is_last, req_stall)

endmodule

bind bracket_tree_level_order bto_checker u_checker (.*);

### test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bto_pkg::*;

   // One readout result as the block should present it.
   typedef struct {
      logic [SYM_W-1:0] node_value;
      logic             tree_empty;
      logic             error_seen;
      logic             is_last;
   } visit_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [SYM_W-1:0] req_symbol = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [SYM_W-1:0] rsp_node_value;
   logic             rsp_tree_empty;
   logic             rsp_error_seen;
   logic             rsp_is_last;

   // Shadow copy of the tree under construction.
   logic [SYM_W-1:0]  tree_vals [MAX_NODES];
   logic [LINK_W-1:0] tree_left [MAX_NODES];
   logic [LINK_W-1:0] tree_right [MAX_NODES];
   logic [LINK_W-1:0] parent_stk [STACK_DEPTH];
   int                tree_count;
   int                stk_level;
   logic [LINK_W-1:0] tree_root;
   logic [LINK_W-1:0] cur_node;
   logic [1:0]        side_sel;
   logic              err_flag;

   // Characters still to be sent, and readout values still to be seen.
   logic [SYM_W-1:0] pending_syms [$];
   visit_type        level_order_q [$];

   int   mismatch_count = 0;
   int   node_budget;
   int   gap_left = 0;
   int   stall_left = 0;
   int   hold_cnt = 0;
   int   valid_cycles = 0;
   logic hold_done = 1'b0;
   logic calm = 1'b0;

   bracket_tree_level_order u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_node_value (rsp_node_value),
      .rsp_tree_empty (rsp_tree_empty),
      .rsp_error_seen (rsp_error_seen),
      .rsp_is_last    (rsp_is_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Back to the empty tree, as after reset or a finished readout.
   function automatic void clear_tree();
      tree_count = 0;
      stk_level  = 0;
      tree_root  = NONE_IDX;
      cur_node   = NONE_IDX;
      side_sel   = MODE_NONE;
      err_flag   = 1'b0;
   endfunction

   // Create a node and hang it under the node on top of the parent stack.
   function automatic void attach_node(logic [SYM_W-1:0] sym);
      int                idx;
      logic [LINK_W-1:0] parent;
      if (tree_count >= MAX_NODES) begin
         err_flag = 1'b1;
         return;
      end
      idx = tree_count;
      tree_count++;
      tree_vals[idx]  = sym;
      tree_left[idx]  = NONE_IDX;
      tree_right[idx] = NONE_IDX;
      cur_node = LINK_W'(idx);
      if (tree_root == NONE_IDX) begin
         tree_root = LINK_W'(idx);
         return;
      end
      // With no side chosen the node simply stays unattached.
      if (side_sel != MODE_LEFT && side_sel != MODE_RIGHT) return;
      if (stk_level == 0) begin
         err_flag = 1'b1;
         return;
      end
      parent = parent_stk[stk_level - 1];
      if (parent >= MAX_NODES) begin
         err_flag = 1'b1;
         return;
      end
      if (side_sel == MODE_LEFT) tree_left[parent] = LINK_W'(idx);
      else tree_right[parent] = LINK_W'(idx);
   endfunction

   // Breadth-first walk from the root, left child before right child.
   function automatic void emit_level_order();
      int        visit [MAX_NODES];
      int        head;
      int        tail;
      int        n;
      int        idx;
      visit_type r;
      if (tree_root == NONE_IDX) begin
         r.node_value = '0;
         r.tree_empty = 1'b1;
         r.error_seen = err_flag;
         r.is_last    = 1'b1;
         level_order_q.push_back(r);
         return;
      end
      head = 0;
      tail = 1;
      n = 0;
      visit[0] = tree_root;
      while (head < tail && n < MAX_NODES) begin
         idx = visit[head];
         head++;
         r.node_value = tree_vals[idx];
         r.tree_empty = 1'b0;
         r.error_seen = err_flag;
         r.is_last    = 1'b0;
         level_order_q.push_back(r);
         n++;
         if (tree_left[idx] < MAX_NODES && tail < MAX_NODES) begin
            visit[tail] = tree_left[idx];
            tail++;
         end
         if (tree_right[idx] < MAX_NODES && tail < MAX_NODES) begin
            visit[tail] = tree_right[idx];
            tail++;
         end
      end
      r = level_order_q.pop_back();
      r.is_last = 1'b1;
      level_order_q.push_back(r);
   endfunction

   // Apply one accepted character to the shadow tree.
   function automatic void parse_symbol(logic [SYM_W-1:0] sym);
      case (sym)
         SYM_END: begin
            emit_level_order();
            clear_tree();
         end
         SYM_OPEN: begin
            if (stk_level >= STACK_DEPTH) begin
               err_flag = 1'b1;
            end else begin
               parent_stk[stk_level] = cur_node;
               stk_level++;
            end
            side_sel = MODE_LEFT;
         end
         SYM_CLOSE: begin
            if (stk_level == 0) err_flag = 1'b1;
            else stk_level--;
         end
         SYM_COMMA: side_sel = MODE_RIGHT;
         default: attach_node(sym);
      endcase
   endfunction

   // Compare one result transfer with the oldest expected value.
   task automatic check_visit();
      visit_type want;
      if (level_order_q.size() == 0) begin
         report_mismatch("unexpected result, node_value", rsp_node_value, -1);
         return;
      end
      want = level_order_q.pop_front();
      if (rsp_node_value !== want.node_value)
         report_mismatch("node_value", rsp_node_value, want.node_value);
      if (rsp_tree_empty !== want.tree_empty)
         report_mismatch("tree_empty", rsp_tree_empty, want.tree_empty);
      if (rsp_error_seen !== want.error_seen)
         report_mismatch("error_seen", rsp_error_seen, want.error_seen);
      if (rsp_is_last !== want.is_last)
         report_mismatch("is_last", rsp_is_last, want.is_last);
   endtask

   // Any character that is neither a bracket, a comma nor the terminator.
   function automatic logic [SYM_W-1:0] node_char();
      logic [SYM_W-1:0] c;
      c = SYM_W'($urandom_range(1, 255));
      while (c == SYM_OPEN || c == SYM_CLOSE || c == SYM_COMMA)
         c = SYM_W'($urandom_range(1, 255));
      return c;
   endfunction

   function automatic void put_line(string s);
      for (int i = 0; i < s.len(); i++) pending_syms.push_back(s[i]);
      pending_syms.push_back(SYM_END);
   endfunction

   // Well-formed bracket notation of a random tree, limited by node_budget.
   function automatic void grow_tree(int depth);
      int shape;
      pending_syms.push_back(node_char());
      node_budget--;
      if (depth >= 6 || node_budget <= 0) return;
      shape = $urandom_range(0, 4);
      if (shape == 0) return;
      pending_syms.push_back(SYM_OPEN);
      if (shape != 3) grow_tree(depth + 1);
      if (shape != 1 && node_budget > 0) begin
         pending_syms.push_back(SYM_COMMA);
         grow_tree(depth + 1);
      end
      pending_syms.push_back(SYM_CLOSE);
   endfunction

   // Stimulus: directed strings first, then random trees with some damage and noise.
   initial begin
      int start;
      int kind;
      int pos;
      int len;
      // Empty tree, simple trees and the extreme character values.
      pending_syms.push_back(SYM_END);
      put_line("A(B,C)");
      pending_syms.push_back(8'hFF);
      pending_syms.push_back(SYM_OPEN);
      pending_syms.push_back(8'h01);
      pending_syms.push_back(SYM_COMMA);
      pending_syms.push_back(8'h80);
      pending_syms.push_back(SYM_CLOSE);
      pending_syms.push_back(SYM_END);
      // Pop of an empty stack, with and without a tree.
      put_line(")A");
      put_line(")");
      // No side chosen, parent slot empty, stack empty, child replaced.
      put_line("AB");
      put_line("(AB");
      put_line("A(B),C");
      put_line("A(B,C,D)");
      put_line("A(B(D,E),C(,F))");
      // A left chain that fills the stack and the node store, then one push
      // and one node too many.
      for (int i = 0; i < MAX_NODES; i++) begin
         pending_syms.push_back(node_char());
         pending_syms.push_back(SYM_OPEN);
      end
      pending_syms.push_back(SYM_OPEN);
      pending_syms.push_back(node_char());
      pending_syms.push_back(SYM_END);

      while (pending_syms.size() < 210) begin
         start = pending_syms.size();
         kind = $urandom_range(0, 9);
         node_budget = $urandom_range(1, 8);
         if (kind < 9) begin
            grow_tree(0);
            // A few strings get one character dropped or replaced.
            if (kind >= 7) begin
               pos = $urandom_range(start, pending_syms.size() - 1);
               case ($urandom_range(0, 3))
                  0: pending_syms.delete(pos);
                  1: pending_syms[pos] = SYM_OPEN;
                  2: pending_syms[pos] = SYM_CLOSE;
                  default: pending_syms[pos] = SYM_COMMA;
               endcase
            end
         end else begin
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 4))
                  0: pending_syms.push_back(SYM_OPEN);
                  1: pending_syms.push_back(SYM_CLOSE);
                  2: pending_syms.push_back(SYM_COMMA);
                  default: pending_syms.push_back(node_char());
               endcase
            end
         end
         pending_syms.push_back(SYM_END);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every character to go out and every result to come back.
      while (reset || pending_syms.size() != 0 || req_valid || level_order_q.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Sender: offers the next character, with short idle bursts until the tail of the run.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         calm <= 1'b0;
         gap_left = 0;
      end else begin
         calm <= (pending_syms.size() <= 25);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_syms.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_symbol <= pending_syms.pop_front();
            end
         end
      end
   end

   // Monitor: predicts on each input transfer, checks each result transfer, drives stall.
   always @(posedge clock) begin
      if (reset) begin
         clear_tree();
         level_order_q.delete();
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (req_valid && !req_stall) parse_symbol(req_symbol);
         if (rsp_valid && !rsp_stall) check_visit();
         if (hold_cnt != 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One long hold-off on the result side, so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         valid_cycles = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid) valid_cycles++;
         if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
         end else if (!hold_done && valid_cycles >= 20) begin
            hold_cnt <= 200;
            hold_done = 1'b1;
         end
      end
   end

endmodule

### files.f
+incdir+hdl
hdl/bto_pkg.sv
hdl/bto_ram.sv
hdl/bto_parser.sv
hdl/bto_walker.sv
hdl/bracket_tree_level_order.sv
hdl/bto_checker.sv
test/tb.sv
